// File: rtl/core/cer_pkg.sv
// Shared definitions for the CIR Euler rate step unit: step codes of the
// microprogram, control word layout, multiplier operand codes, register indexes.
// No dependencies.
`default_nettype none

package cer_pkg;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Microprogram step addresses.
  localparam step_t ST_IDLE      = 4'd0;
  localparam step_t ST_MUL_DIFF  = 4'd1;
  localparam step_t ST_MUL_KAPPA = 4'd2;
  localparam step_t ST_MUL_RATE  = 4'd3;
  localparam step_t ST_SQRT_GO   = 4'd4;
  localparam step_t ST_SQRT_WAIT = 4'd5;
  localparam step_t ST_MUL_SIGMA = 4'd6;
  localparam step_t ST_LOAD_S    = 4'd7;
  localparam step_t ST_MUL_SLO   = 4'd8;
  localparam step_t ST_MUL_SHI   = 4'd9;
  localparam step_t ST_ACC       = 4'd10;
  localparam step_t ST_FINISH    = 4'd11;

  // Multiplier operand selection.
  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MUL_NONE  = 3'd0;
  localparam mul_op_t MUL_D_DT  = 3'd1;
  localparam mul_op_t MUL_K_A   = 3'd2;
  localparam mul_op_t MUL_R_DT  = 3'd3;
  localparam mul_op_t MUL_SIG_Q = 3'd4;
  localparam mul_op_t MUL_SLO_Z = 3'd5;
  localparam mul_op_t MUL_SHI_Z = 3'd6;

  // Condition that lets the sequencer leave the current step.
  typedef logic [1:0] cond_t;
  localparam cond_t COND_ALWAYS = 2'd0;
  localparam cond_t COND_IN     = 2'd1;
  localparam cond_t COND_SQ     = 2'd2;
  localparam cond_t COND_OUT    = 2'd3;

  typedef struct packed {
    logic    accept;
    mul_op_t mul_op;
    logic    ld_dmag;
    logic    sq_start;
    logic    ld_s;
    logic    ld_acc;
    logic    add_acc;
    logic    finish;
    cond_t   cond;
    step_t   nxt;
  } ctrl_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THETA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_R0    = 3'd4;

  localparam int Z_FRAC = 12;

endpackage

`default_nettype wire

// File: rtl/core/cer_ucode_rom.sv
// Microprogram store of the CIR Euler rate step unit: maps a step address
// to its control word. Depends on cer_pkg.
`default_nettype none

module cer_ucode_rom
  import cer_pkg::*;
(
  input  wire step_t step,
  output ctrl_t      ctrl
);

  always_comb begin
    ctrl = '0;
    unique case (step)
      ST_IDLE: begin
        ctrl.accept = 1'b1;
        ctrl.cond   = COND_IN;
        ctrl.nxt    = ST_MUL_DIFF;
      end
      ST_MUL_DIFF: begin
        ctrl.mul_op = MUL_D_DT;
        ctrl.nxt    = ST_MUL_KAPPA;
      end
      ST_MUL_KAPPA: begin
        ctrl.mul_op = MUL_K_A;
        ctrl.nxt    = ST_MUL_RATE;
      end
      ST_MUL_RATE: begin
        ctrl.ld_dmag = 1'b1;
        ctrl.mul_op  = MUL_R_DT;
        ctrl.nxt     = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        ctrl.sq_start = 1'b1;
        ctrl.nxt      = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        ctrl.cond = COND_SQ;
        ctrl.nxt  = ST_MUL_SIGMA;
      end
      ST_MUL_SIGMA: begin
        ctrl.mul_op = MUL_SIG_Q;
        ctrl.nxt    = ST_LOAD_S;
      end
      ST_LOAD_S: begin
        ctrl.ld_s = 1'b1;
        ctrl.nxt  = ST_MUL_SLO;
      end
      ST_MUL_SLO: begin
        ctrl.mul_op = MUL_SLO_Z;
        ctrl.nxt    = ST_MUL_SHI;
      end
      ST_MUL_SHI: begin
        ctrl.ld_acc = 1'b1;
        ctrl.mul_op = MUL_SHI_Z;
        ctrl.nxt    = ST_ACC;
      end
      ST_ACC: begin
        ctrl.add_acc = 1'b1;
        ctrl.nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        ctrl.finish = 1'b1;
        ctrl.cond   = COND_OUT;
        ctrl.nxt    = ST_IDLE;
      end
      default: begin
        ctrl.nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/cer_isqrt.sv
// Iterative integer square root, one result bit per cycle (restoring method).
// Standalone; used by the CIR Euler rate step unit.
`default_nettype none

module cer_isqrt #(
  parameter int QW = 28
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  wire [2*QW-1:0] radicand,
  output logic           done,
  output logic [QW-1:0]  root
);

  localparam int RW = 2 * QW;
  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] rad_r;
  logic [QW:0]   rem_r;
  logic [QW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;

  logic [QW+2:0] rem_sh;
  logic [QW+2:0] trial;
  logic          ge;

  assign rem_sh = {rem_r, rad_r[RW-1 -: 2]};
  assign trial  = (QW + 3)'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= ge ? (QW + 1)'(rem_sh - trial) : rem_sh[QW:0];
      root_r <= {root_r[QW-2:0], ge};
    end
  end

  assign done = !busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: rtl/core/cir_euler_rate_step_unit.sv
// Top level of the CIR Euler rate step unit: microcode sequencer, shared
// 32x32 multiplier datapath and configuration registers.
// Depends on cer_pkg, cer_ucode_rom and cer_isqrt.
//
// One word in gives one word out: an Euler step with full truncation of a
// CIR short-rate path, r' = r + kappa*(theta-r)*dt + sigma*sqrt(r*dt)*Z,
// clamped at zero and saturated at the top of the 32-bit range. A word with
// start_path set first reloads the stored rate from the R0 configuration
// register. The block works on one word at a time; its pace is set by the
// square root unit, which produces one root bit per cycle, and by the
// single multiplier that the microprogram uses for all six partial products in
// turn. A finished result waits in the output register while the next word is
// taken. The user must write configuration through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Indexes beyond the register list are ignored.
`default_nettype none

module cir_euler_rate_step_unit
  import cer_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]          cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_start_path,
  input  wire signed [15:0]   in_normal_sample,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [31:0]         out_next_rate
);

  localparam int QW   = (33 + FRAC_BITS) / 2;
  localparam int RW   = 2 * QW;
  localparam int DW   = 64 - FRAC_BITS;
  localparam int SW   = 32 + QW - FRAC_BITS;
  localparam int AW   = SW + 16;
  localparam int FW   = AW - Z_FRAC;
  localparam int MW   = (DW > FW) ? DW : FW;
  localparam int SUMW = MW + 3;

  // Configuration registers.
  logic [31:0] kappa_r, theta_r, sigma_r, dt_r, r0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= '0;
      theta_r <= '0;
      sigma_r <= '0;
      dt_r    <= '0;
      r0_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KAPPA: kappa_r <= cfg_data;
        CFG_THETA: theta_r <= cfg_data;
        CFG_SIGMA: sigma_r <= cfg_data;
        CFG_DT:    dt_r    <= cfg_data;
        CFG_R0:    r0_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  step_t step_r, step_nxt;
  ctrl_t ctrl;
  logic  cond_met;
  logic  sq_done;
  logic  out_valid_r;
  logic  in_take;

  cer_ucode_rom u_rom (
    .step (step_r),
    .ctrl (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS: cond_met = 1'b1;
      COND_IN:     cond_met = in_valid;
      COND_SQ:     cond_met = sq_done;
      COND_OUT:    cond_met = !out_valid_r || !out_stall;
      default:     cond_met = 1'b1;
    endcase
  end

  assign step_nxt = cond_met ? ctrl.nxt : step_r;
  assign in_stall = !ctrl.accept;
  assign in_take  = in_valid && ctrl.accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Datapath.
  logic [31:0]    rate_r;
  logic [31:0]    rate_sel;
  logic [31:0]    d_r;
  logic           dneg_r;
  logic [15:0]    zmag_r;
  logic           zneg_r;
  logic [15:0]    z_bits;
  logic [63:0]    prod_r;
  logic [31:0]    mul_a, mul_b;
  logic [DW-1:0]  dmag_r;
  logic [SW-1:0]  s_r;
  logic [AW-1:0]  acc_r;
  logic [QW-1:0]  q;
  logic [31:0]    out_rate_r;
  logic [31:0]    step_result;

  assign rate_sel = in_start_path ? r0_r : rate_r;
  assign z_bits   = in_normal_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else if (in_take) begin
      rate_r <= rate_sel;
    end else if (ctrl.finish && cond_met) begin
      rate_r <= step_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      if (theta_r >= rate_sel) begin
        d_r    <= theta_r - rate_sel;
        dneg_r <= 1'b0;
      end else begin
        d_r    <= rate_sel - theta_r;
        dneg_r <= 1'b1;
      end
      zneg_r <= z_bits[15];
      zmag_r <= z_bits[15] ? (~z_bits + 16'd1) : z_bits;
    end
  end

  always_comb begin
    unique case (ctrl.mul_op)
      MUL_D_DT: begin
        mul_a = d_r;
        mul_b = dt_r;
      end
      MUL_K_A: begin
        mul_a = kappa_r;
        mul_b = prod_r[63:32];
      end
      MUL_R_DT: begin
        mul_a = rate_r;
        mul_b = dt_r;
      end
      MUL_SIG_Q: begin
        mul_a = sigma_r;
        mul_b = 32'(q);
      end
      MUL_SLO_Z: begin
        mul_a = s_r[31:0];
        mul_b = 32'(zmag_r);
      end
      MUL_SHI_Z: begin
        mul_a = 32'(s_r[SW-1:32]);
        mul_b = 32'(zmag_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctrl.ld_dmag) begin
      dmag_r <= prod_r[63:FRAC_BITS];
    end
    if (ctrl.ld_s) begin
      s_r <= prod_r[SW+FRAC_BITS-1:FRAC_BITS];
    end
    if (ctrl.ld_acc) begin
      acc_r <= prod_r[AW-1:0];
    end else if (ctrl.add_acc) begin
      // The upper partial product of s*|Z| weighs 2^32.
      acc_r <= acc_r + {prod_r[AW-33:0], 32'd0};
    end
  end

  cer_isqrt #(
    .QW (QW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.sq_start),
    .radicand (RW'({prod_r[63:32], {FRAC_BITS{1'b0}}})),
    .done     (sq_done),
    .root     (q)
  );

  // Exact signed sum of rate, drift and diffusion, then clamp and saturate.
  logic [SUMW-1:0] dext, fext, sum;

  assign dext = SUMW'(dmag_r);
  assign fext = SUMW'(acc_r[AW-1:Z_FRAC]);
  assign sum  = SUMW'(rate_r)
              + (dneg_r ? (~dext + SUMW'(1)) : dext)
              + (zneg_r ? (~fext + SUMW'(1)) : fext);

  always_comb begin
    priority if (sum[SUMW-1]) begin
      step_result = '0;
    end else if (|sum[SUMW-2:32]) begin
      step_result = '1;
    end else begin
      step_result = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish && cond_met) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish && cond_met) begin
      out_rate_r <= step_result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_rate = out_rate_r;

  // An accepted word always starts the program at its first arithmetic step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (step_r == ST_MUL_DIFF))
    else $error("accepted word did not start the microprogram");

  // A result only appears out of the final step of the program.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == ST_FINISH))
    else $error("result raised outside the final step");

  // The root must be ready before it is multiplied by sigma.
  a_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_MUL_SIGMA) |-> sq_done)
    else $error("square root still busy when its result is used");

  // No result word may be overwritten while it is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_rate_r)))
    else $error("pending result was lost or overwritten");

endmodule

`default_nettype wire
